// ===== src/trdss_pkg.sv =====
// Shared types and constants for the transmit ring DMA segment scheduler.
// Depends on nothing; every other file refers to it by scoped names.
package trdss_pkg;

    // Field widths of the input and result beats.
    localparam int OP_W     = 2;
    localparam int MLEN_W   = 10;
    localparam int BYTE_W   = 8;
    localparam int ROFF_W   = 9;
    localparam int DOFF_W   = 9;
    localparam int DLEN_W   = 9;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [MLEN_W-1:0] t_mlen;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [ROFF_W-1:0] t_roff;
    typedef logic [DOFF_W-1:0] t_doff;
    typedef logic [DLEN_W-1:0] t_dlen;

    // Operation codes of an input beat.
    localparam t_op OP_BEGIN = 2'd0;
    localparam t_op OP_BYTE  = 2'd1;
    localparam t_op OP_DONE  = 2'd2;
    localparam t_op OP_READ  = 2'd3;

    // Result flags and segment descriptor produced by the ring controller.
    typedef struct packed {
        logic  accepted;
        logic  dma_start;
        t_doff dma_offset;
        t_dlen dma_length;
        logic  dma_busy;
    } t_result;

endpackage

// ===== src/trdss_if.sv =====
// Valid/ready channel interfaces for the input and result beats.
// Depends on trdss_pkg for the field types.
interface trdss_in_if;
    logic            valid;
    logic            ready;
    trdss_pkg::t_op   operation;
    trdss_pkg::t_mlen msg_length;
    trdss_pkg::t_byte data_byte;
    trdss_pkg::t_roff read_offset;

    modport source (output valid, output operation, output msg_length,
                    output data_byte, output read_offset, input ready);
    modport sink   (input valid, input operation, input msg_length,
                    input data_byte, input read_offset, output ready);
endinterface

interface trdss_out_if;
    logic             valid;
    logic             ready;
    logic             accepted;
    logic             dma_start;
    trdss_pkg::t_doff dma_offset;
    trdss_pkg::t_dlen dma_length;
    trdss_pkg::t_byte read_data;
    logic             dma_busy;

    modport source (output valid, output accepted, output dma_start, output dma_offset,
                    output dma_length, output read_data, output dma_busy, input ready);
    modport sink   (input valid, input accepted, input dma_start, input dma_offset,
                    input dma_length, input read_data, input dma_busy, output ready);
endinterface

// ===== src/tx_ring_dma_segment_scheduler_unit.sv =====
// Top level of the transmit ring DMA segment scheduler.
// Depends on trdss_pkg, trdss_if, trdss_ring_ctrl and trdss_byte_ram.

// The block takes one input beat per clock and returns exactly one result beat
// for each, in the cycle after acceptance; the result sits in an output register,
// and a new beat is taken whenever that register is empty or is being drained
// in the same cycle, so a stalled result stops the input only for as long as
// it is not taken. Pointers and the DMA busy flag live in registers and are
// updated in the accepting cycle; the byte buffer is a single synchronous
// memory with one write port for message bytes and one registered read port
// for DMA reads, whose data appears alongside the registered result. The buffer has no
// reset or clearing pass: reading an offset never written returns undefined
// data. DEPTH sets the buffer size; segment offsets and lengths are reported
// in 9 bits.
module tx_ring_dma_segment_scheduler_unit #(
    parameter int DEPTH = 512
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    trdss_in_if.sink      i_in,
    trdss_out_if.source   o_out
);

    localparam int AW = $clog2(DEPTH);

    logic               accept;
    trdss_pkg::t_result res;
    logic               we;
    logic [AW-1:0]      waddr;
    trdss_pkg::t_byte   wdata;
    logic               re;
    logic [AW-1:0]      raddr;
    trdss_pkg::t_byte   rdata;

    logic               r_valid;
    trdss_pkg::t_result r_res;
    logic               r_is_read;

    // Input beat is taken when the result register is free or draining.
    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    trdss_ring_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_operation   (i_in.operation),
        .i_msg_length  (i_in.msg_length),
        .i_data_byte   (i_in.data_byte),
        .i_read_offset (i_in.read_offset),
        .o_res         (res),
        .o_we          (we),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_re          (re),
        .o_raddr       (raddr)
    );

    trdss_byte_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload; read data comes straight from the buffer's read register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res     <= res;
            r_is_read <= (i_in.operation == trdss_pkg::OP_READ);
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.accepted   = r_res.accepted;
    assign o_out.dma_start  = r_res.dma_start;
    assign o_out.dma_offset = r_res.dma_offset;
    assign o_out.dma_length = r_res.dma_length;
    assign o_out.dma_busy   = r_res.dma_busy;
    assign o_out.read_data  = r_is_read ? rdata : '0;

    // A started segment always leaves the DMA busy.
    a_start_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.dma_start) |-> o_out.dma_busy)
        else $error("segment start without busy");

    // Without a start the segment descriptor reads as zero.
    a_idle_desc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.dma_start) |->
            (o_out.dma_offset == '0 && o_out.dma_length == '0))
        else $error("segment descriptor without start");

    // An admitted message never starts a segment in the same beat.
    a_accept_nostart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.accepted) |-> !o_out.dma_start)
        else $error("segment start on message admission");

endmodule

// ===== src/trdss_byte_ram.sv =====
// Byte buffer of the transmit ring: one write port, one registered read port.
// Depends on trdss_pkg for the byte type.
module trdss_byte_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  trdss_pkg::t_byte i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output trdss_pkg::t_byte o_rdata
);

    trdss_pkg::t_byte r_mem [DEPTH];
    trdss_pkg::t_byte r_rdata;

    // Synchronous write and read; read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/trdss_ring_ctrl.sv =====
// Ring pointer state, message admission and DMA segment scheduling.
// Depends on trdss_pkg; drives the buffer ports of trdss_byte_ram.
module trdss_ring_ctrl #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  trdss_pkg::t_op     i_operation,
    input  trdss_pkg::t_mlen   i_msg_length,
    input  trdss_pkg::t_byte   i_data_byte,
    input  trdss_pkg::t_roff   i_read_offset,
    output trdss_pkg::t_result o_res,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output trdss_pkg::t_byte   o_wdata,
    output logic               o_re,
    output logic [AW-1:0]      o_raddr
);

    localparam int        CW      = (AW + 1 > trdss_pkg::MLEN_W) ? AW + 1 : trdss_pkg::MLEN_W;
    localparam int        ROFF_SZ = 1 << trdss_pkg::ROFF_W;
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);

    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [AW-1:0]    r_wp,   n_wp;
    logic [AW-1:0]    r_seg,  n_seg;
    logic             r_busy, n_busy;
    trdss_pkg::t_mlen r_rem,  n_rem;

    logic [AW:0]   used;
    logic [AW:0]   free_sp;
    logic [AW-1:0] wp_inc;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail_adv;
    logic [AW-1:0] seg_len;
    logic [trdss_pkg::ROFF_W:0] roff_red;

    // Segment length from tail: up to head, or up to the buffer end on wrap.
    function automatic logic [AW-1:0] seg_size(input logic [AW-1:0] h, input logic [AW-1:0] t);
        logic [AW-1:0] n;
        if (h > t) begin
            n = h - t;
        end else begin
            n = AW'(DEPTH) - t;
        end
        return n;
    endfunction

    // Occupancy, free space and pointer increments.
    always_comb begin
        if (r_head >= r_tail) begin
            used = {1'b0, r_head} - {1'b0, r_tail};
        end else begin
            used = {1'b0, r_head} + DEPTH_W - {1'b0, r_tail};
        end
        free_sp  = DEPTH_W - 1'b1 - used;
        wp_inc   = (r_wp == LAST) ? '0 : r_wp + 1'b1;
        tail_sum = {1'b0, r_tail} + {1'b0, r_seg};
        tail_adv = (tail_sum == DEPTH_W) ? '0 : tail_sum[AW-1:0];
    end

    // Read offset wrapped into the buffer by conditional subtraction of
    // DEPTH times descending powers of two.
    always_comb begin
        roff_red = {1'b0, i_read_offset};
        for (int k = 7; k >= 0; k--) begin
            if ((DEPTH << k) < ROFF_SZ) begin
                if (roff_red >= (trdss_pkg::ROFF_W + 1)'(DEPTH << k)) begin
                    roff_red = roff_red - (trdss_pkg::ROFF_W + 1)'(DEPTH << k);
                end
            end
        end
    end

    // Per-beat state update and result.
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_wp    = r_wp;
        n_seg   = r_seg;
        n_busy  = r_busy;
        n_rem   = r_rem;
        o_res   = '0;
        o_we    = 1'b0;
        o_re    = 1'b0;
        seg_len = '0;
        if (i_accept) begin
            unique case (i_operation)
                trdss_pkg::OP_BEGIN: begin
                    if (r_rem == '0 && i_msg_length != '0
                        && CW'(i_msg_length) <= CW'(free_sp)) begin
                        o_res.accepted = 1'b1;
                        n_rem          = i_msg_length;
                        n_wp           = r_head;
                    end
                end
                trdss_pkg::OP_BYTE: begin
                    if (r_rem != '0) begin
                        o_we  = 1'b1;
                        n_wp  = wp_inc;
                        n_rem = r_rem - 1'b1;
                        // Last byte publishes the message and may start a segment.
                        if (r_rem == trdss_pkg::t_mlen'(1)) begin
                            n_head = wp_inc;
                            if (!r_busy && wp_inc != r_tail) begin
                                seg_len          = seg_size(wp_inc, r_tail);
                                n_busy           = 1'b1;
                                n_seg            = seg_len;
                                o_res.dma_start  = 1'b1;
                                o_res.dma_offset = trdss_pkg::DOFF_W'(r_tail);
                                o_res.dma_length = trdss_pkg::DLEN_W'(seg_len);
                            end
                        end
                    end
                end
                trdss_pkg::OP_DONE: begin
                    if (r_busy) begin
                        n_tail = tail_adv;
                        n_busy = 1'b0;
                        if (tail_adv != r_head) begin
                            seg_len          = seg_size(r_head, tail_adv);
                            n_busy           = 1'b1;
                            n_seg            = seg_len;
                            o_res.dma_start  = 1'b1;
                            o_res.dma_offset = trdss_pkg::DOFF_W'(tail_adv);
                            o_res.dma_length = trdss_pkg::DLEN_W'(seg_len);
                        end
                    end
                end
                trdss_pkg::OP_READ: begin
                    o_re = 1'b1;
                end
                default: begin
                end
            endcase
        end
        o_res.dma_busy = n_busy;
    end

    assign o_waddr = r_wp;
    assign o_wdata = i_data_byte;
    assign o_raddr = AW'(roff_red);

    // Pointer and flag registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_wp   <= '0;
            r_seg  <= '0;
            r_busy <= 1'b0;
            r_rem  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_wp   <= n_wp;
            r_seg  <= n_seg;
            r_busy <= n_busy;
            r_rem  <= n_rem;
        end
    end

endmodule
